@@ hdl/ptb_pkg.sv @@
package ptb_pkg;

    localparam int DEF_MAX_LEN  = 256;
    localparam int DEF_ALPHABET = 256;
    localparam int SYMBOL_W     = 8;
    localparam int LEN_W        = 9;
    localparam int START_W      = 8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RD_NODE,
        S_RD_HIST,
        S_CMP,
        S_RD_EDGE,
        S_RD_KEY,
        S_DECIDE,
        S_CREATE,
        S_UPDATE,
        S_OUT
    } ptb_state_t;

    typedef struct packed {
        logic accept;
        logic start_walk;
        logic rd_node;
        logic rd_hist;
        logic step;
        logic set_parent;
        logic set_lookup;
        logic rd_edge;
        logic rd_key;
        logic take_hit;
        logic start_walk2;
        logic take_link;
        logic create;
        logic update;
        logic set_ovf;
        logic load_out;
    } ptb_cmd_t;

    typedef struct packed {
        logic full;
        logic match;
        logic hit;
        logic par_root;
        logic out_busy;
    } ptb_stat_t;

endpackage

@@ hdl/ptb_in_if.sv @@
interface ptb_in_if;
    import ptb_pkg::*;

    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;
    logic                first;

    modport source (output valid, symbol, first, input ready);
    modport sink (input valid, symbol, first, output ready);

endinterface

@@ hdl/ptb_out_if.sv @@
interface ptb_out_if;
    import ptb_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEN_W-1:0]   suffix_len;
    logic [LEN_W-1:0]   best_len;
    logic [START_W-1:0] best_start;
    logic               new_node;
    logic               overflow;

    modport source (output valid, suffix_len, best_len, best_start, new_node, overflow,
                    input ready);
    modport sink (input valid, suffix_len, best_len, best_start, new_node, overflow,
                  output ready);

endinterface

@@ hdl/ptb_ctrl.sv @@
module ptb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ptb_pkg::ptb_stat_t  stat,
    output ptb_pkg::ptb_cmd_t   cmd
);
    import ptb_pkg::*;

    ptb_state_t state_reg;
    ptb_state_t state_next;
    logic       phase2_reg;
    logic       phase2_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase2_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase2_reg <= phase2_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        phase2_next = phase2_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next  = S_CHECK;
                    phase2_next = 1'b0;
                end
            end
            S_CHECK:
            begin
                if (stat.full)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_RD_NODE;
                end
            end
            S_RD_NODE: state_next = S_RD_HIST;
            S_RD_HIST: state_next = S_CMP;
            S_CMP:
            begin
                if (stat.match)
                begin
                    state_next = S_RD_EDGE;
                end
                else
                begin
                    state_next = S_RD_NODE;
                end
            end
            S_RD_EDGE: state_next = S_RD_KEY;
            S_RD_KEY:  state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (stat.hit)
                begin
                    if (phase2_reg)
                    begin
                        state_next = S_CREATE;
                    end
                    else
                    begin
                        state_next = S_UPDATE;
                    end
                end
                else if (phase2_reg || stat.par_root)
                begin
                    state_next = S_CREATE;
                end
                else
                begin
                    state_next  = S_RD_NODE;
                    phase2_next = 1'b1;
                end
            end
            S_CREATE: state_next = S_UPDATE;
            S_UPDATE: state_next = S_OUT;
            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_CHECK:
            begin
                if (stat.full)
                begin
                    cmd.set_ovf = 1'b1;
                end
                else
                begin
                    cmd.start_walk = 1'b1;
                end
            end
            S_RD_NODE: cmd.rd_node = 1'b1;
            S_RD_HIST: cmd.rd_hist = 1'b1;
            S_CMP:
            begin
                if (stat.match)
                begin
                    cmd.set_lookup = 1'b1;
                    cmd.set_parent = !phase2_reg;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_RD_EDGE: cmd.rd_edge = 1'b1;
            S_RD_KEY:  cmd.rd_key = 1'b1;
            S_DECIDE:
            begin
                if (stat.hit)
                begin
                    if (phase2_reg)
                    begin
                        cmd.take_link = 1'b1;
                    end
                    else
                    begin
                        cmd.take_hit = 1'b1;
                    end
                end
                else if (!phase2_reg && !stat.par_root)
                begin
                    cmd.start_walk2 = 1'b1;
                end
            end
            S_CREATE: cmd.create = 1'b1;
            S_UPDATE: cmd.update = 1'b1;
            S_OUT:    cmd.load_out = !stat.out_busy;
            default:  cmd = '0;
        endcase
    end

endmodule

@@ hdl/ptb_dp.sv @@
module ptb_dp #(
    parameter int MAX_LEN  = ptb_pkg::DEF_MAX_LEN,
    parameter int ALPHABET = ptb_pkg::DEF_ALPHABET
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ptb_pkg::SYMBOL_W-1:0]  symbol,
    input  logic                          first,
    input  ptb_pkg::ptb_cmd_t             cmd,
    output ptb_pkg::ptb_stat_t            stat,
    ptb_out_if.source                     results
);
    import ptb_pkg::*;

    localparam int NODE_CAP   = MAX_LEN + 2;
    localparam int PW         = $clog2(MAX_LEN + 1);
    localparam int HW         = $clog2(MAX_LEN);
    localparam int NW         = $clog2(NODE_CAP);
    localparam int CW         = $clog2(NODE_CAP + 1);
    localparam int LW         = PW + 1;
    localparam int SW         = $clog2(ALPHABET);
    localparam int KW         = NW + SW;
    localparam int EDGE_DEPTH = NODE_CAP * (1 << SW);
    localparam int SYM_COUNT  = 1 << SYMBOL_W;

    typedef struct packed {
        logic signed [LW-1:0] len;
        logic [NW-1:0]        link;
        logic [KW-1:0]        key;
    } node_rec_t;

    logic [SW-1:0] fold_lut [SYM_COUNT];

    for (genvar gi = 0; gi < SYM_COUNT; gi++)
    begin : g_fold
        assign fold_lut[gi] = SW'(gi % ALPHABET);
    end

    logic [SW-1:0]  hist_mem [MAX_LEN];
    node_rec_t      node_mem [NODE_CAP];
    logic [NW-1:0]  edge_mem [EDGE_DEPTH];

    logic [PW-1:0]        pos_reg;
    logic [CW-1:0]        count_reg;
    logic [NW-1:0]        cur_reg;
    logic [PW-1:0]        best_len_reg;
    logic [HW-1:0]        best_start_reg;
    logic                 out_valid_reg;

    logic [SW-1:0]        c_reg;
    logic [NW-1:0]        v_reg;
    logic signed [LW-1:0] v_len_reg;
    logic [NW-1:0]        v_link_reg;
    logic                 neg_len_reg;
    logic                 m_neg_reg;
    logic [NW-1:0]        par_reg;
    logic signed [LW-1:0] par_len_reg;
    logic [NW-1:0]        par_link_reg;
    logic [NW-1:0]        lk_reg;
    logic [NW-1:0]        link_reg;
    node_rec_t            node_rd_reg;
    logic [SW-1:0]        hist_rd_reg;
    logic [NW-1:0]        tgt_rd_reg;
    logic [PW-1:0]        cur_len_reg;
    logic                 created_reg;
    logic                 ovf_reg;
    logic [LEN_W-1:0]     out_suffix_reg;
    logic [LEN_W-1:0]     out_best_len_reg;
    logic [START_W-1:0]   out_best_start_reg;
    logic                 out_new_reg;
    logic                 out_ovf_reg;

    logic signed [LW-1:0] eff_len;
    logic [NW-1:0]        eff_link;
    logic signed [PW+1:0] mirror;
    logic [HW-1:0]        hist_idx;
    logic [KW-1:0]        edge_key;
    logic [KW-1:0]        new_key;
    logic signed [LW-1:0] new_len;
    logic                 room;
    logic [NW-1:0]        node_addr;
    logic [PW-1:0]        start_calc;

    // The two roots live outside the node memory.
    always_comb
    begin
        if (v_reg == NW'(0))
        begin
            eff_len  = '0;
            eff_link = NW'(1);
        end
        else if (v_reg == NW'(1))
        begin
            eff_len  = '1;
            eff_link = NW'(0);
        end
        else
        begin
            eff_len  = node_rd_reg.len;
            eff_link = node_rd_reg.link;
        end
    end

    assign mirror     = $signed({2'b00, pos_reg}) - (PW + 2)'(eff_len)
                        - $signed((PW + 2)'(1));
    assign hist_idx   = mirror[HW-1:0];
    assign edge_key   = {lk_reg, c_reg};
    assign new_key    = {par_reg, c_reg};
    assign new_len    = par_len_reg + $signed(LW'(2));
    assign room       = count_reg < CW'(NODE_CAP);
    assign node_addr  = cmd.rd_key ? tgt_rd_reg : v_reg;
    assign start_calc = pos_reg + PW'(1) - cur_len_reg;

    assign stat.full     = pos_reg >= PW'(MAX_LEN);
    assign stat.match    = neg_len_reg || (!m_neg_reg && (hist_rd_reg == c_reg));
    assign stat.hit      = (tgt_rd_reg >= NW'(2)) && (CW'(tgt_rd_reg) < count_reg)
                           && (node_rd_reg.key == edge_key);
    assign stat.par_root = par_reg == NW'(1);
    assign stat.out_busy = out_valid_reg && !results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            count_reg      <= CW'(2);
            cur_reg        <= '0;
            best_len_reg   <= '0;
            best_start_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept && first)
            begin
                pos_reg        <= '0;
                count_reg      <= CW'(2);
                cur_reg        <= '0;
                best_len_reg   <= '0;
                best_start_reg <= '0;
            end
            if (cmd.take_hit)
            begin
                cur_reg <= tgt_rd_reg;
            end
            if (cmd.create)
            begin
                if (room)
                begin
                    cur_reg   <= count_reg[NW-1:0];
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    cur_reg <= '0;
                end
            end
            if (cmd.update)
            begin
                pos_reg <= pos_reg + PW'(1);
                if (cur_len_reg > best_len_reg)
                begin
                    best_len_reg   <= cur_len_reg;
                    best_start_reg <= start_calc[HW-1:0];
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            c_reg       <= fold_lut[symbol];
            created_reg <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        if (cmd.set_ovf)
        begin
            ovf_reg <= 1'b1;
        end
        if (cmd.start_walk)
        begin
            v_reg    <= cur_reg;
            link_reg <= '0;
        end
        if (cmd.step)
        begin
            v_reg <= v_link_reg;
        end
        if (cmd.start_walk2)
        begin
            v_reg <= par_link_reg;
        end
        if (cmd.rd_hist)
        begin
            v_len_reg   <= eff_len;
            v_link_reg  <= eff_link;
            neg_len_reg <= eff_len[LW-1];
            m_neg_reg   <= mirror[PW+1];
        end
        if (cmd.set_lookup)
        begin
            lk_reg <= v_reg;
        end
        if (cmd.set_parent)
        begin
            par_reg      <= v_reg;
            par_len_reg  <= v_len_reg;
            par_link_reg <= v_link_reg;
        end
        if (cmd.take_hit)
        begin
            cur_len_reg <= node_rd_reg.len[PW-1:0];
        end
        if (cmd.take_link)
        begin
            link_reg <= tgt_rd_reg;
        end
        if (cmd.create)
        begin
            if (room)
            begin
                created_reg <= 1'b1;
                cur_len_reg <= new_len[PW-1:0];
            end
            else
            begin
                cur_len_reg <= '0;
            end
        end
        if (cmd.load_out)
        begin
            out_suffix_reg     <= ovf_reg ? '0 : LEN_W'(cur_len_reg);
            out_best_len_reg   <= LEN_W'(best_len_reg);
            out_best_start_reg <= START_W'(best_start_reg);
            out_new_reg        <= created_reg && !ovf_reg;
            out_ovf_reg        <= ovf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_walk)
        begin
            hist_mem[pos_reg[HW-1:0]] <= c_reg;
        end
        if (cmd.rd_hist)
        begin
            hist_rd_reg <= hist_mem[hist_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.create && room)
        begin
            node_mem[count_reg[NW-1:0]] <= '{len: new_len, link: link_reg, key: new_key};
        end
        if (cmd.rd_node || cmd.rd_key)
        begin
            node_rd_reg <= node_mem[node_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.create && room)
        begin
            edge_mem[new_key] <= count_reg[NW-1:0];
        end
        if (cmd.rd_edge)
        begin
            tgt_rd_reg <= edge_mem[edge_key];
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.suffix_len = out_suffix_reg;
    assign results.best_len   = out_best_len_reg;
    assign results.best_start = out_best_start_reg;
    assign results.new_node   = out_new_reg;
    assign results.overflow   = out_ovf_reg;

endmodule

@@ hdl/palindromic_tree_builder.sv @@
// Builds a palindromic tree over a byte stream, one request at a time, and returns one result
// per symbol: the longest palindromic suffix, and the longest palindrome so far with its start.
// A request with first set starts a new string; symbols past MAX_LEN are dropped and flagged.
// Each suffix-link test reads the node memory, reads the history and compares, and each
// transition lookup reads the edge memory, reads the node key and decides. A symbol that
// creates a node walks the suffix links a second time to find the new node's link, unless
// it hangs from the length -1 root; a dropped symbol goes straight to the output state.
// The walks are amortized constant per symbol.
// A finished result that finds the previous one still untaken waits in the last state, with
// the input not ready, until the receiver takes the previous one.
// The edge store needs no clearing pass: an edge counts only if its target is a live node whose
// recorded parent edge matches, so a new string starts at once.
module palindromic_tree_builder #(
    parameter int MAX_LEN  = ptb_pkg::DEF_MAX_LEN,
    parameter int ALPHABET = ptb_pkg::DEF_ALPHABET
) (
    input  logic       clk,
    input  logic       rst_n,
    ptb_in_if.sink     symbols,
    ptb_out_if.source  results
);
    import ptb_pkg::*;

    ptb_cmd_t  cmd;
    ptb_stat_t stat;

    ptb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (symbols.valid),
        .in_ready (symbols.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ptb_dp #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .symbol  (symbols.symbol),
        .first   (symbols.first),
        .cmd     (cmd),
        .stat    (stat),
        .results (results)
    );

endmodule

@@ dv/palindromic_tree_builder_checker.sv @@
module palindromic_tree_builder_checker #(
    parameter int MAX_LEN  = ptb_pkg::DEF_MAX_LEN,
    parameter int ALPHABET = ptb_pkg::DEF_ALPHABET
) (
    input  logic clk,
    input  logic rst_n,
    ptb_in_if    symbols,
    ptb_out_if   results,
    output int   errors,
    output int   pending,
    output int   checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import ptb_pkg::*;

    localparam int NODE_CAP = MAX_LEN + 2;

    typedef struct packed {
        logic [LEN_W-1:0]   suffix_len;
        logic [LEN_W-1:0]   best_len;
        logic [START_W-1:0] best_start;
        logic               new_node;
        logic               overflow;
    } pal_result_t;

    logic [SYMBOL_W-1:0] text [MAX_LEN];
    int                  text_len;
    int                  pal_len [NODE_CAP];
    int                  pal_link [NODE_CAP];
    int                  child [int];
    int                  pal_count;
    int                  tail_node;
    int                  longest;
    int                  longest_at;
    pal_result_t         expected_q [$];

    function automatic void restart_string();
        text_len = 0;
        foreach (pal_len[i])
        begin
            pal_len[i]  = 0;
            pal_link[i] = 0;
        end
        pal_len[1]  = -1;
        pal_link[0] = 1;
        pal_link[1] = 0;
        child.delete();
        pal_count  = 2;
        tail_node  = 0;
        longest    = 0;
        longest_at = 0;
    endfunction

    function automatic bit extends_with(int node, int at, int c);
        int m;
        if (pal_len[node] < 0)
            return 1'b1;
        m = at - pal_len[node] - 1;
        if (m < 0)
            return 1'b0;
        return text[m] == c;
    endfunction

    function automatic int longest_extendable(int node, int at, int c);
        int steps;
        steps = 0;
        while (!extends_with(node, at, c) && steps <= NODE_CAP)
        begin
            node = pal_link[node];
            steps++;
        end
        return (steps > NODE_CAP) ? 1 : node;
    endfunction

    function automatic pal_result_t extend_string(logic [SYMBOL_W-1:0] sym, logic mark);
        pal_result_t r;
        int          c;
        int          at;
        int          parent;
        int          key;
        int          link_parent;
        int          link;
        int          tail_len;
        c = int'(sym) % ALPHABET;
        r = '0;
        if (mark)
            restart_string();
        if (text_len >= MAX_LEN)
        begin
            r.best_len   = longest[LEN_W-1:0];
            r.best_start = longest_at[START_W-1:0];
            r.overflow   = 1'b1;
            return r;
        end
        at       = text_len;
        text[at] = c[SYMBOL_W-1:0];
        parent   = longest_extendable(tail_node, at, c);
        key      = parent * ALPHABET + c;
        if (!child.exists(key))
        begin
            link = 0;
            if (pal_len[parent] >= 0)
            begin
                link_parent = longest_extendable(pal_link[parent], at, c);
                if (child.exists(link_parent * ALPHABET + c))
                    link = child[link_parent * ALPHABET + c];
            end
            if (pal_count < NODE_CAP)
            begin
                pal_len[pal_count]  = pal_len[parent] + 2;
                pal_link[pal_count] = link;
                child[key]          = pal_count;
                pal_count++;
                r.new_node = 1'b1;
            end
        end
        tail_node = child.exists(key) ? child[key] : 0;
        tail_len  = (pal_len[tail_node] < 0) ? 0 : pal_len[tail_node];
        if (tail_len > longest)
        begin
            longest    = tail_len;
            longest_at = at + 1 - tail_len;
        end
        text_len     = at + 1;
        r.suffix_len = tail_len[LEN_W-1:0];
        r.best_len   = longest[LEN_W-1:0];
        r.best_start = longest_at[START_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pal_result_t got;
        pal_result_t want;
        if (!rst_n)
        begin
            restart_string();
            expected_q.delete();
            errors  = 0;
            checked = 0;
        end
        else
        begin
            if (symbols.valid && symbols.ready)
                expected_q.insert(expected_q.size(),
                                  extend_string(symbols.symbol, symbols.first));
            if (results.valid && results.ready)
            begin
                got = {results.suffix_len, results.best_len, results.best_start,
                       results.new_node, results.overflow};
                checked++;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no request pending: %p", $time, got);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display({"%0t: expected suffix_len=%0d best_len=%0d ",
                                  "best_start=%0d new_node=%0b overflow=%0b, got ",
                                  "suffix_len=%0d best_len=%0d best_start=%0d ",
                                  "new_node=%0b overflow=%0b"}, $time,
                                 want.suffix_len, want.best_len, want.best_start,
                                 want.new_node, want.overflow,
                                 got.suffix_len, got.best_len, got.best_start,
                                 got.new_node, got.overflow);
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

@@ dv/palindromic_tree_builder_test.sv @@
module palindromic_tree_builder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ptb_pkg::*;

    localparam int ITEM_TARGET = 1550;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AFTER  = 600;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 20;
    localparam int NOISE       = 0;

    typedef enum int {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    logic clk;
    logic rst_n;
    logic symbol_taken;
    int   errors;
    int   pending;
    int   checked;
    int   cycle_count;
    int   burst_left;
    int   sent_count;
    int   string_count;
    int   string_pos;
    int   dropped_count;
    int   long_count;

    ptb_in_if  sym_if ();
    ptb_out_if res_if ();

    palindromic_tree_builder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .symbols (sym_if),
        .results (res_if)
    );

    palindromic_tree_builder_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .symbols (sym_if),
        .results (res_if),
        .errors  (errors),
        .pending (pending),
        .checked (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            symbol_taken <= 1'b0;
        else
            symbol_taken <= sym_if.valid && sym_if.ready;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** palindromic_tree_builder: FAILED **");
        $finish;
    end

    // The receiver changes its stall pattern every so often, and once holds off for a long
    // stretch while requests keep coming so that the block backs up.
    initial
    begin : receiver
        rx_mode_t mode;
        int       phase_left;
        int       hold_left;
        bit       hold_done;
        mode         = RX_OPEN;
        phase_left   = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_if.ready = 1'b0;
                hold_left--;
            end
            else if (!hold_done && sent_count >= HOLD_AFTER)
            begin
                hold_done    = 1'b1;
                hold_left    = HOLD_CYCLES;
                res_if.ready = 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    mode       = rx_mode_t'($urandom_range(0, 3));
                    phase_left = $urandom_range(20, 200);
                end
                phase_left--;
                case (mode)
                    RX_OPEN:   res_if.ready = 1'b1;
                    RX_HALF:   res_if.ready = 1'($urandom_range(0, 1));
                    RX_SPARSE: res_if.ready = ($urandom_range(0, 3) == 0);
                    default:   res_if.ready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send_symbol(input logic [SYMBOL_W-1:0] sym, input logic mark);
        if (burst_left == 0)
        begin
            sym_if.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        sym_if.valid  = 1'b1;
        sym_if.symbol = sym;
        sym_if.first  = mark;
        do
            @(negedge clk);
        while (!symbol_taken);
        sent_count++;
        if (mark)
        begin
            string_count++;
            string_pos = 0;
        end
        if (string_pos >= DEF_MAX_LEN)
            dropped_count++;
        else
            string_pos++;
    endtask

    task automatic send_string(input int length, input int n_letters);
        logic [SYMBOL_W-1:0] letters [4];
        foreach (letters[i])
            letters[i] = SYMBOL_W'($urandom);
        for (int i = 0; i < length; i++)
            send_symbol((n_letters == NOISE) ? SYMBOL_W'($urandom)
                                             : letters[$urandom_range(0, n_letters - 1)],
                        i == 0);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        sym_if.valid  = 1'b0;
        sym_if.symbol = '0;
        sym_if.first  = 1'b0;
        burst_left    = 0;
        sent_count    = 0;
        string_count  = 1;
        string_pos    = 0;
        dropped_count = 0;
        long_count    = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // The first string relies on the tree left by reset rather than a first mark.
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hAA, 1'b1);
        send_symbol(8'hAA, 1'b0);
        send_symbol(8'hAA, 1'b0);
        send_symbol(8'hAA, 1'b0);
        send_symbol(8'h55, 1'b1);
        send_symbol(8'h80, 1'b0);
        send_symbol(8'h01, 1'b0);
        send_symbol(8'h80, 1'b0);
        send_symbol(8'h55, 1'b0);
        send_symbol(8'h7F, 1'b1);
        send_symbol(8'hFE, 1'b1);
        send_symbol(8'h01, 1'b0);
        send_symbol(8'hFE, 1'b0);

        // Two strings run past the capacity: one of a single letter, one of two letters.
        while (sent_count < ITEM_TARGET)
        begin
            if ((long_count == 0 && sent_count >= 400) || (long_count == 1 && sent_count >= 900))
            begin
                long_count++;
                send_string(DEF_MAX_LEN + $urandom_range(3, 12), long_count);
            end
            else if ($urandom_range(0, 7) == 0)
                send_string($urandom_range(1, 40), NOISE);
            else
                send_string($urandom_range(1, 40), $urandom_range(1, 4));
        end
        sym_if.valid = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("Sent %0d symbols in %0d strings; %0d arrived after a string was full.",
                 sent_count, string_count, dropped_count);
        $display("Checked %0d results, %0d mismatched.", checked, errors);
        if (errors == 0)
            $display("** palindromic_tree_builder: PASSED **");
        else
            $display("** palindromic_tree_builder: FAILED **");
        $finish;
    end

endmodule
